[rtl/gda_pkg.sv]
// Shared types, constants and calendar helpers for the Gregorian date adder.
// No dependencies; used by every other file of the block.
package gda_pkg;

   localparam int YEAR_W     = 14;  // year field width on the ports
   localparam int YEAR_INT_W = 15;  // internal year, holds results past the field range
   localparam int MONTH_W    = 4;
   localparam int DAY_W      = 5;
   localparam int DAYS_W     = 20;  // configured day count
   localparam int REM_W      = 21;  // day count plus start day

   localparam logic [DAYS_W-1:0]     DAYS_RESET = 20'd11574;
   localparam logic [YEAR_INT_W-1:0] LEAP_CYCLE = 15'd400;
   localparam logic [YEAR_INT_W-1:0] CYCLE_LAST = 15'd399;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [DAY_W-1:0] LEN_28 = 5'd28;
   localparam logic [DAY_W-1:0] LEN_29 = 5'd29;
   localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
   localparam logic [DAY_W-1:0] LEN_31 = 5'd31;

   // Leap test from the year's position within the 400-year cycle.
   function automatic logic is_leap(input logic [YEAR_INT_W-1:0] pos);
      logic century;
      century = (pos == 15'd0) || (pos == 15'd100) || (pos == 15'd200) || (pos == 15'd300);
      return (pos[1:0] == 2'b00) && !(century && (pos != 15'd0));
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = LEN_31;
         MONTH_FEB: len = leap ? LEN_29 : LEN_28;
         default: len = LEN_30;
      endcase
      return len;
   endfunction

endpackage

[rtl/gda_channels.sv]
// Handshake channels of the Gregorian date adder: request, response, register write.
// Depends on gda_pkg for field widths.
interface gda_req_if;
   logic                            valid;
   logic                            ready;
   logic [gda_pkg::YEAR_W-1:0]      start_year;
   logic [gda_pkg::MONTH_W-1:0]     start_month;
   logic [gda_pkg::DAY_W-1:0]       start_day;
   modport source (output valid, start_year, start_month, start_day, input ready);
   modport sink   (input valid, start_year, start_month, start_day, output ready);
endinterface

interface gda_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [gda_pkg::YEAR_W-1:0]      end_year;
   logic [gda_pkg::MONTH_W-1:0]     end_month;
   logic [gda_pkg::DAY_W-1:0]       end_day;
   logic                            year_overflow;
   modport source (output valid, end_year, end_month, end_day, year_overflow, input ready);
   modport sink   (input valid, end_year, end_month, end_day, year_overflow, output ready);
endinterface

interface gda_csr_if;
   logic                            valid;
   logic                            ready;
   logic [gda_pkg::DAYS_W-1:0]      days_to_add;
   modport source (output valid, days_to_add, input ready);
   modport sink   (input valid, days_to_add, output ready);
endinterface

[rtl/gda_sub_unit.sv]
// Shared subtract-and-compare unit of the date adder.
// Depends on gda_pkg for the operand width.
module gda_sub_unit (
   input  logic [gda_pkg::REM_W-1:0] minuend,
   input  logic [gda_pkg::REM_W-1:0] subtrahend,
   output logic [gda_pkg::REM_W-1:0] diff,
   output logic                      borrow
);

   // borrow set means minuend < subtrahend
   assign {borrow, diff} = {1'b0, minuend} - {1'b0, subtrahend};

endmodule

[rtl/gregorian_date_add_days.sv]
// Top level of the Gregorian date adder: sequencer, registers and output stage.
// Depends on gda_pkg, gda_channels and gda_sub_unit.
//
//   channel  modport  transfer moves
//   req_if   sink     start_year, start_month, start_day
//   rsp_if   source   end_year, end_month, end_day, year_overflow
//   csr_if   sink     days_to_add (always ready)
//
// After the request transfer the shared subtractor runs reduce steps, which bring cy
// (the year of the month before the start month) to its position within the 400-year
// cycle, then walk steps month by month, then a finish step. The finish step stalls while
// an earlier result still waits on rsp_if. Synchronous active-high reset restores
// days_to_add and empties the output stage. A new request is taken while a finished
// result still waits on rsp_if.
module gregorian_date_add_days (
   input  logic       clock,
   input  logic       reset,
   gda_req_if.sink    req_if,
   gda_rsp_if.source  rsp_if,
   gda_csr_if.sink    csr_if
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_REDUCE = 4'b0010,
      ST_WALK   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                            state_ff, state_in;
   logic [gda_pkg::DAYS_W-1:0]           days_ff, days_in;
   logic [gda_pkg::REM_W-1:0]            rem_ff, rem_in;
   logic [gda_pkg::YEAR_INT_W-1:0]       cy_ff, cy_in;
   logic [gda_pkg::YEAR_INT_W-1:0]       pos_ff, pos_in;   // cy modulo 400
   logic [gda_pkg::MONTH_W-1:0]          cm_ff, cm_in;
   logic                                 out_valid_ff, out_valid_in;
   logic [gda_pkg::YEAR_INT_W-1:0]       out_year_ff, out_year_in;
   logic [gda_pkg::MONTH_W-1:0]          out_month_ff, out_month_in;
   logic [gda_pkg::DAY_W-1:0]            out_day_ff, out_day_in;

   logic [gda_pkg::REM_W-1:0]            sub_a, sub_b, sub_diff;
   logic                                 sub_borrow;

   logic [gda_pkg::YEAR_INT_W-1:0]       in_year;
   logic [gda_pkg::MONTH_W-1:0]          in_month;
   logic [gda_pkg::MONTH_W-1:0]          nm;
   logic [gda_pkg::YEAR_INT_W-1:0]       ny;
   logic [gda_pkg::YEAR_INT_W-1:0]       pos_next;
   logic                                 wrap;
   logic                                 cy_leap;
   logic [gda_pkg::DAY_W-1:0]            next_len;
   logic                                 req_xfer;
   logic                                 out_free;

   gda_sub_unit u_sub (
      .minuend    (sub_a),
      .subtrahend (sub_b),
      .diff       (sub_diff),
      .borrow     (sub_borrow)
   );

   assign req_xfer = req_if.valid && req_if.ready;
   assign out_free = !out_valid_ff || rsp_if.ready;

   assign req_if.ready         = (state_ff == ST_IDLE);
   assign csr_if.ready         = 1'b1;
   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.end_year      = out_year_ff[gda_pkg::YEAR_W-1:0];
   assign rsp_if.end_month     = out_month_ff;
   assign rsp_if.end_day       = out_day_ff;
   assign rsp_if.year_overflow = out_year_ff[gda_pkg::YEAR_INT_W-1];

   always_comb begin
      in_year = {1'b0, req_if.start_year};
      if (in_year == '0) begin
         in_year = 15'd1;
      end
      in_month = req_if.start_month;
      if (in_month == '0) begin
         in_month = gda_pkg::MONTH_JAN;
      end else if (in_month > gda_pkg::MONTH_DEC) begin
         in_month = gda_pkg::MONTH_DEC;
      end
   end

   // month following the current position
   always_comb begin
      wrap     = (cm_ff == gda_pkg::MONTH_DEC);
      nm       = wrap ? gda_pkg::MONTH_JAN : cm_ff + 4'd1;
      ny       = wrap ? cy_ff + 15'd1 : cy_ff;
      pos_next = (pos_ff == gda_pkg::CYCLE_LAST) ? '0 : pos_ff + 15'd1;
      cy_leap  = gda_pkg::is_leap(pos_ff);
      // February only follows January, so the leap year is always cy
      next_len = gda_pkg::month_length(nm, cy_leap);
   end

   always_comb begin
      if (state_ff == ST_REDUCE) begin
         sub_a = {6'd0, pos_ff};
         sub_b = {6'd0, gda_pkg::LEAP_CYCLE};
      end else begin
         sub_a = rem_ff;
         sub_b = {16'd0, next_len};
      end
   end

   always_comb begin
      state_in     = state_ff;
      days_in      = days_ff;
      rem_in       = rem_ff;
      cy_in        = cy_ff;
      pos_in       = pos_ff;
      cm_in        = cm_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_year_in  = out_year_ff;
      out_month_in = out_month_ff;
      out_day_in   = out_day_ff;

      if (csr_if.valid) begin
         days_in = csr_if.days_to_add;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               rem_in = {1'b0, days_ff} + {16'd0, req_if.start_day};
               if (in_month == gda_pkg::MONTH_JAN) begin
                  cm_in = gda_pkg::MONTH_DEC;
                  cy_in = in_year - 15'd1;
               end else begin
                  cm_in = in_month - 4'd1;
                  cy_in = in_year;
               end
               pos_in   = cy_in;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (sub_borrow) begin
               state_in = ST_WALK;
            end else begin
               pos_in = sub_diff[gda_pkg::YEAR_INT_W-1:0];
            end
         end
         ST_WALK: begin
            if (sub_borrow) begin
               state_in = ST_FINISH;
            end else begin
               rem_in = sub_diff;
               cm_in  = nm;
               cy_in  = ny;
               if (wrap) begin
                  pos_in = pos_next;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (rem_ff == '0) begin
                  out_year_in  = cy_ff;
                  out_month_in = cm_ff;
                  out_day_in   = gda_pkg::month_length(cm_ff, cy_leap);
               end else begin
                  out_year_in  = ny;
                  out_month_in = nm;
                  out_day_in   = rem_ff[gda_pkg::DAY_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         days_ff      <= gda_pkg::DAYS_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         days_ff      <= days_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      cy_ff        <= cy_in;
      pos_ff       <= pos_in;
      cm_ff        <= cm_in;
      out_year_ff  <= out_year_in;
      out_month_ff <= out_month_in;
      out_day_ff   <= out_day_in;
   end

endmodule
